### rtl/battery_power_mode_manager_defines.svh
// Assertion macros shared by the battery power mode manager RTL.
`ifndef BATTERY_POWER_MODE_MANAGER_DEFINES_SVH
`define BATTERY_POWER_MODE_MANAGER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BPMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bpmm check failed");

// Next-cycle implication, disabled while in reset.
`define BPMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bpmm check failed");

`endif

### rtl/bpmm_pkg.sv
// Types, constants and the contrast table of the battery power mode manager.
package bpmm_pkg;

	localparam int unsigned MV_W    = 14;
	localparam int unsigned TIME_W  = 10;
	localparam int unsigned IDLE_W  = 6;
	localparam int unsigned SLEEP_W = 8;
	localparam int unsigned DUTY_W  = 8;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [TIME_W-1:0]  MICRO_STEP  = 10'd800;
	localparam logic [TIME_W-1:0]  MILLI_STEP  = 10'd8;
	localparam logic [TIME_W:0]    WRAP_1000   = 11'd1000;
	localparam logic [TIME_W-1:0]  LED_MS      = 10'd50;
	localparam logic [IDLE_W-1:0]  IDLE_MAX    = 6'd60;
	localparam logic [SLEEP_W-1:0] SLEEP_MAX   = 8'd255;

	localparam logic [DUTY_W-1:0] DUTY_RESET    = 8'd127;
	localparam logic [DUTY_W-1:0] DUTY_ZERO     = 8'd0;
	localparam logic [DUTY_W-1:0] DUTY_START    = 8'd160;
	localparam logic [DUTY_W-1:0] DUTY_TOO_LOW  = 8'd210;

	localparam logic [MV_W-1:0] MAX_RATED_RST    = 14'd5300;
	localparam logic [MV_W-1:0] BATTERY_FULL_RST = 14'd4900;
	localparam logic [MV_W-1:0] NO_EXTERNAL_RST  = 14'd4500;
	localparam logic [MV_W-1:0] ON_BATTERY_RST   = 14'd4000;
	localparam logic [MV_W-1:0] BATTERY_LOW_RST  = 14'd3600;

	typedef enum logic [2:0] {
		MODE_START    = 3'd0,
		MODE_FORCE    = 3'd1,
		MODE_CHARGING = 3'd2,
		MODE_EXTERNAL = 3'd3,
		MODE_BATTERY  = 3'd4,
		MODE_LOW      = 3'd5,
		MODE_OVERFLOW = 3'd6
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_RATED    = 3'd0,
		CFG_BATTERY_FULL = 3'd1,
		CFG_NO_EXTERNAL  = 3'd2,
		CFG_ON_BATTERY   = 3'd3,
		CFG_BATTERY_LOW  = 3'd4,
		CFG_SAMPLE_EN    = 3'd5,
		CFG_WDOG_HOLD    = 3'd6,
		CFG_FORCE_CHARGE = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [MV_W-1:0] sample_mv;
		logic            clear_idle_timer;
		logic            clear_sleep_timer;
	} tick_in_t;

	typedef struct packed {
		logic               charge_on;
		logic [DUTY_W-1:0]  contrast_duty;
		logic               led_on;
		logic [2:0]         power_mode;
		logic               watchdog_kick;
		logic [TIME_W-1:0]  seconds;
		logic [TIME_W-1:0]  milliseconds;
		logic [IDLE_W-1:0]  idle_seconds;
		logic [SLEEP_W-1:0] sleep_seconds;
	} tick_out_t;

	// Five-step contrast table over the reading.
	function automatic logic [DUTY_W-1:0] table_contrast(input logic [MV_W-1:0] mv);
		logic [DUTY_W-1:0] duty;
		if (mv > 14'd4800)      duty = 8'd0;
		else if (mv > 14'd4600) duty = 8'd50;
		else if (mv > 14'd4300) duty = 8'd100;
		else if (mv > 14'd4100) duty = 8'd200;
		else                    duty = 8'd249;
		return duty;
	endfunction

endpackage

### rtl/bpmm_if.sv
// Valid/ready channel interfaces for tick inputs and tick results.
interface bpmm_in_if;
	import bpmm_pkg::*;
	logic     valid;
	logic     ready;
	tick_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bpmm_out_if;
	import bpmm_pkg::*;
	logic      valid;
	logic      ready;
	tick_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/battery_power_mode_manager.sv
// A tick beat taken into the input register moves its result into the result
// register on advance. Throughput: one tick per clock unless tick_out stalls;
// the two form a two-deep pipeline, so a new tick is taken while a result waits.
// The clock, counter and mode update is one short compare/add pass per tick.
// Reset (arst_n low, asynchronous): thresholds to defaults, counters and mode
// cleared, contrast 127, both pipeline stages empty.
module battery_power_mode_manager (
	input  logic                                   clk,
	input  logic                                   arst_n,
	bpmm_in_if.sink                                tick_in,
	bpmm_out_if.source                             tick_out,
	input  logic                                   cfg_we,
	input  logic [bpmm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [bpmm_pkg::MV_W-1:0]              cfg_wdata
);
	import bpmm_pkg::*;

	`include "battery_power_mode_manager_defines.svh"

	// Configuration registers
	logic [MV_W-1:0] max_rated_q, battery_full_q, no_external_q, on_battery_q, battery_low_q;
	logic            sample_en_q, wdog_hold_q, force_charge_q;

	// Pipeline and state
	logic              s1_valid_q;
	tick_in_t          s1_data_s1;
	logic              out_valid_q;
	tick_out_t         out_data_q;
	logic              advance;

	logic [MV_W-1:0]    reading_q;
	mode_t              mode_q;
	logic               charge_q;
	logic [DUTY_W-1:0]  contrast_q;
	logic [TIME_W-1:0]  micro_q, milli_q, second_q;
	logic [1:0]         sec_mod3_q;
	logic [IDLE_W-1:0]  idle_q;
	logic [SLEEP_W-1:0] sleep_q;

	// Next-state values
	logic [MV_W-1:0]    reading_d;
	mode_t              mode_d;
	logic               charge_d;
	logic [DUTY_W-1:0]  contrast_d;
	logic [TIME_W-1:0]  micro_d, milli_d, second_d;
	logic [1:0]         sec_mod3_d;
	logic [IDLE_W-1:0]  idle_d;
	logic [SLEEP_W-1:0] sleep_d;
	logic               led_d;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rated_q    <= MAX_RATED_RST;
			battery_full_q <= BATTERY_FULL_RST;
			no_external_q  <= NO_EXTERNAL_RST;
			on_battery_q   <= ON_BATTERY_RST;
			battery_low_q  <= BATTERY_LOW_RST;
			sample_en_q    <= 1'b0;
			wdog_hold_q    <= 1'b0;
			force_charge_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_MAX_RATED:    max_rated_q    <= cfg_wdata;
				CFG_BATTERY_FULL: battery_full_q <= cfg_wdata;
				CFG_NO_EXTERNAL:  no_external_q  <= cfg_wdata;
				CFG_ON_BATTERY:   on_battery_q   <= cfg_wdata;
				CFG_BATTERY_LOW:  battery_low_q  <= cfg_wdata;
				CFG_SAMPLE_EN:    sample_en_q    <= cfg_wdata[0];
				CFG_WDOG_HOLD:    wdog_hold_q    <= cfg_wdata[0];
				CFG_FORCE_CHARGE: force_charge_q <= cfg_wdata[0];
				default:          ;
			endcase
		end
	end

	// Advance the input stage when the result register is free or being drained
	assign advance       = s1_valid_q && (!out_valid_q || tick_out.ready);
	assign tick_in.ready = !s1_valid_q || advance;

	// Compute clock, counters and power decision for the tick in stage 1
	always_comb begin
		logic [TIME_W:0] micro_sum;
		logic [TIME_W:0] milli_sum;
		logic            sec_roll;
		logic [IDLE_W-1:0]  idle_base;
		logic [SLEEP_W-1:0] sleep_base;

		idle_base  = s1_data_s1.clear_idle_timer  ? '0 : idle_q;
		sleep_base = s1_data_s1.clear_sleep_timer ? '0 : sleep_q;

		// Microseconds carry one extra millisecond
		micro_sum = {1'b0, micro_q} + {1'b0, MICRO_STEP};
		milli_sum = {1'b0, milli_q} + {1'b0, MILLI_STEP};
		if (micro_sum >= WRAP_1000) begin
			micro_sum = micro_sum - WRAP_1000;
			milli_sum = milli_sum + 11'd1;
		end
		sec_roll = (milli_sum >= WRAP_1000);
		if (sec_roll) milli_sum = milli_sum - WRAP_1000;
		micro_d = micro_sum[TIME_W-1:0];
		milli_d = milli_sum[TIME_W-1:0];

		second_d   = second_q;
		sec_mod3_d = sec_mod3_q;
		idle_d     = idle_base;
		sleep_d    = sleep_base;
		if (sec_roll) begin
			if ({1'b0, second_q} + 11'd1 >= WRAP_1000) begin
				second_d   = '0;
				sec_mod3_d = 2'd0;
			end else begin
				second_d   = second_q + 10'd1;
				sec_mod3_d = (sec_mod3_q == 2'd2) ? 2'd0 : sec_mod3_q + 2'd1;
			end
			if (idle_base < IDLE_MAX)   idle_d  = idle_base + 6'd1;
			if (sleep_base < SLEEP_MAX) sleep_d = sleep_base + 8'd1;
		end

		led_d = (sec_mod3_d == 2'd0) && (milli_d < LED_MS);

		reading_d = sample_en_q ? s1_data_s1.sample_mv : reading_q;

		// Pick mode, charge switch and contrast; first matching band wins
		mode_d     = mode_q;
		charge_d   = charge_q;
		contrast_d = contrast_q;
		if (force_charge_q) begin
			mode_d     = MODE_FORCE;
			charge_d   = 1'b1;
			contrast_d = table_contrast(reading_d);
		end else if (reading_d > max_rated_q) begin
			mode_d     = MODE_OVERFLOW;
			charge_d   = 1'b1;
			contrast_d = DUTY_ZERO;
		end else if (reading_d > battery_full_q) begin
			if (mode_q == MODE_START) begin
				charge_d   = 1'b1;
				contrast_d = DUTY_START;
				mode_d     = MODE_CHARGING;
			end else begin
				if (charge_q) begin
					charge_d   = 1'b0;
					contrast_d = DUTY_ZERO;
				end
				mode_d = MODE_EXTERNAL;
			end
		end else if (reading_d > on_battery_q) begin
			charge_d   = 1'b1;
			mode_d     = (reading_d > no_external_q) ? MODE_CHARGING : MODE_BATTERY;
			contrast_d = table_contrast(reading_d);
		end else if (reading_d > battery_low_q) begin
			charge_d   = 1'b1;
			mode_d     = MODE_BATTERY;
			contrast_d = table_contrast(reading_d);
		end else begin
			charge_d = 1'b1;
			if (mode_q == MODE_BATTERY) begin
				mode_d = MODE_LOW;
			end else begin
				mode_d     = MODE_BATTERY;
				contrast_d = DUTY_TOO_LOW;
			end
		end
	end

	// Hold control state and valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			reading_q   <= '0;
			mode_q      <= MODE_START;
			charge_q    <= 1'b0;
			contrast_q  <= DUTY_RESET;
			micro_q     <= '0;
			milli_q     <= '0;
			second_q    <= '0;
			sec_mod3_q  <= 2'd0;
			idle_q      <= '0;
			sleep_q     <= '0;
		end else begin
			if (tick_in.ready) s1_valid_q <= tick_in.valid;
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (tick_out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				reading_q  <= reading_d;
				mode_q     <= mode_d;
				charge_q   <= charge_d;
				contrast_q <= contrast_d;
				micro_q    <= micro_d;
				milli_q    <= milli_d;
				second_q   <= second_d;
				sec_mod3_q <= sec_mod3_d;
				idle_q     <= idle_d;
				sleep_q    <= sleep_d;
			end
		end
	end

	// Capture input beat and result payload
	always_ff @(posedge clk) begin
		if (tick_in.valid && tick_in.ready) s1_data_s1 <= tick_in.data;
		if (advance) begin
			out_data_q.charge_on     <= charge_d;
			out_data_q.contrast_duty <= contrast_d;
			out_data_q.led_on        <= led_d;
			out_data_q.power_mode    <= mode_d;
			out_data_q.watchdog_kick <= !wdog_hold_q;
			out_data_q.seconds       <= second_d;
			out_data_q.milliseconds  <= milli_d;
			out_data_q.idle_seconds  <= idle_d;
			out_data_q.sleep_seconds <= sleep_d;
		end
	end

	assign tick_out.valid = out_valid_q;
	assign tick_out.data  = out_data_q;

	`BPMM_ASSERT_NEXT(a_adv_fills_out, clk, arst_n, advance, out_valid_q)
	`BPMM_ASSERT_NEXT(a_stall_keeps_s1, clk, arst_n, s1_valid_q && !advance, s1_valid_q)
	`BPMM_ASSERT_NEXT(a_force_mode, clk, arst_n, advance && force_charge_q, (mode_q == MODE_FORCE) && charge_q)
	`BPMM_ASSERT_NOW(a_time_range, clk, arst_n, out_valid_q, (out_data_q.milliseconds < LED_MS || !out_data_q.led_on) && out_data_q.idle_seconds <= IDLE_MAX && second_q < 10'd1000)

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the battery power mode manager: random tick beats against a predictor.
module testbench;
	import bpmm_pkg::*;

	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_CYCLES = 150;
	localparam int PHASE_ITEMS  = 185;
	localparam int LONG_ITEMS   = 190;
	localparam int QUEUE_DEPTH  = 256;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [MV_W-1:0]      cfg_wdata;

	bpmm_in_if  tick_in_ch ();
	bpmm_out_if tick_out_ch ();

	battery_power_mode_manager dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_in   (tick_in_ch),
		.tick_out  (tick_out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Ticks waiting to be sent and results still owed by the block
	tick_in_t  pending_ticks [$];
	tick_out_t expected_reports [$];
	int        fail_count = 0;
	bit        fast_run = 1'b0;

	// Shadow of the register file
	logic [MV_W-1:0] limit_mv [5] = '{MAX_RATED_RST, BATTERY_FULL_RST, NO_EXTERNAL_RST,
		ON_BATTERY_RST, BATTERY_LOW_RST};
	logic            sample_en_q = 1'b0;
	logic            wdog_hold_q = 1'b0;
	logic            force_q     = 1'b0;

	// Shadow of the manager state
	logic [MV_W-1:0]    reading_q = '0;
	mode_t              mode_q    = MODE_START;
	logic               charge_q  = 1'b0;
	logic [DUTY_W-1:0]  duty_q    = 8'd127;
	logic [TIME_W-1:0]  micro_q   = '0;
	logic [TIME_W-1:0]  milli_q   = '0;
	logic [TIME_W-1:0]  sec_q     = '0;
	logic [IDLE_W-1:0]  idle_q    = '0;
	logic [SLEEP_W-1:0] sleep_q   = '0;

	// Five-step contrast over the reading
	function automatic logic [DUTY_W-1:0] duty_for(input logic [MV_W-1:0] mv);
		if (mv > 14'd4800) return 8'd0;
		if (mv > 14'd4600) return 8'd50;
		if (mv > 14'd4300) return 8'd100;
		if (mv > 14'd4100) return 8'd200;
		return 8'd249;
	endfunction

	function automatic tick_out_t predict_tick(input tick_in_t beat);
		logic [TIME_W:0] micro_sum;
		logic [TIME_W:0] milli_sum;
		tick_out_t       res;
		if (beat.clear_idle_timer) idle_q = '0;
		if (beat.clear_sleep_timer) sleep_q = '0;

		// advance 800 us and 8 ms, carry into ms and s
		micro_sum = {1'b0, micro_q} + 11'd800;
		milli_sum = {1'b0, milli_q} + 11'd8;
		if (micro_sum >= 11'd1000) begin
			milli_sum = milli_sum + 11'd1;
			micro_sum = micro_sum - 11'd1000;
		end
		if (milli_sum >= 11'd1000) begin
			milli_sum = milli_sum - 11'd1000;
			sec_q = (sec_q == 10'd999) ? '0 : sec_q + 10'd1;
			if (idle_q < 6'd60) idle_q = idle_q + 6'd1;
			if (sleep_q != 8'd255) sleep_q = sleep_q + 8'd1;
		end
		micro_q = micro_sum[TIME_W-1:0];
		milli_q = milli_sum[TIME_W-1:0];

		if (sample_en_q) reading_q = beat.sample_mv;

		// pick mode, charge switch and contrast; first matching band wins
		if (force_q) begin
			mode_q   = MODE_FORCE;
			charge_q = 1'b1;
			duty_q   = duty_for(reading_q);
		end else if (reading_q > limit_mv[CFG_MAX_RATED]) begin
			mode_q   = MODE_OVERFLOW;
			charge_q = 1'b1;
			duty_q   = 8'd0;
		end else if (reading_q > limit_mv[CFG_BATTERY_FULL]) begin
			if (mode_q == MODE_START) begin
				charge_q = 1'b1;
				duty_q   = 8'd160;
				mode_q   = MODE_CHARGING;
			end else begin
				if (charge_q) begin
					charge_q = 1'b0;
					duty_q   = 8'd0;
				end
				mode_q = MODE_EXTERNAL;
			end
		end else if (reading_q > limit_mv[CFG_ON_BATTERY]) begin
			charge_q = 1'b1;
			mode_q   = (reading_q > limit_mv[CFG_NO_EXTERNAL]) ? MODE_CHARGING : MODE_BATTERY;
			duty_q   = duty_for(reading_q);
		end else if (reading_q > limit_mv[CFG_BATTERY_LOW]) begin
			charge_q = 1'b1;
			mode_q   = MODE_BATTERY;
			duty_q   = duty_for(reading_q);
		end else begin
			charge_q = 1'b1;
			if (mode_q == MODE_BATTERY) begin
				mode_q = MODE_LOW;
			end else begin
				mode_q = MODE_BATTERY;
				duty_q = 8'd210;
			end
		end

		res.charge_on     = charge_q;
		res.contrast_duty = duty_q;
		res.led_on        = (sec_q % 3 == 0) && (milli_q < 10'd50);
		res.power_mode    = mode_q;
		res.watchdog_kick = !wdog_hold_q;
		res.seconds       = sec_q;
		res.milliseconds  = milli_q;
		res.idle_seconds  = idle_q;
		res.sleep_seconds = sleep_q;
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Readings that often sit on band and table edges, else random or at the extremes
	function automatic logic [MV_W-1:0] pick_sample();
		int mv;
		int table_edge [4] = '{4100, 4300, 4600, 4800};
		case ($urandom_range(0, 9))
			0, 1, 2: mv = int'(limit_mv[$urandom_range(0, 4)]) + int'($urandom_range(0, 2)) - 1;
			3:       mv = table_edge[$urandom_range(0, 3)] + int'($urandom_range(0, 2)) - 1;
			4, 5, 6: mv = $urandom_range(3000, 6000);
			7, 8:    mv = $urandom_range(0, 16383);
			default: mv = $urandom_range(0, 1) ? 16383 : 0;
		endcase
		if (mv < 0) mv = 0;
		if (mv > 16383) mv = 16383;
		return mv[MV_W-1:0];
	endfunction

	task automatic queue_tick(input logic [MV_W-1:0] mv, input logic clr_idle,
		input logic clr_sleep);
		tick_in_t beat;
		while (pending_ticks.size() >= QUEUE_DEPTH) @(negedge clk);
		beat.sample_mv         = mv;
		beat.clear_idle_timer  = clr_idle;
		beat.clear_sleep_timer = clr_sleep;
		pending_ticks.push_back(beat);
	endtask

	// Write one register; only called while the block is idle
	task automatic write_reg(input cfg_reg_t idx, input logic [MV_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			CFG_SAMPLE_EN:    sample_en_q = value[0];
			CFG_WDOG_HOLD:    wdog_hold_q = value[0];
			CFG_FORCE_CHARGE: force_q     = value[0];
			default:          limit_mv[idx] = value;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Hold until every queued tick is sent and every result is back
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_ticks.size() != 0 || tick_in_ch.valid || expected_reports.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Tick driver: present queued beats with a random gap after each
	int send_wait;
	int send_max;
	int sent_cnt;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_in_ch.valid <= 1'b0;
			tick_in_ch.data  <= '0;
			send_wait        <= 0;
			send_max         <= 8;
			sent_cnt         <= 0;
		end else if (tick_in_ch.valid && !tick_in_ch.ready) begin
			// hold the beat until taken
		end else if (send_wait != 0) begin
			tick_in_ch.valid <= 1'b0;
			send_wait        <= send_wait - 1;
		end else if (pending_ticks.size() != 0) begin
			tick_in_ch.data  <= pending_ticks.pop_front();
			tick_in_ch.valid <= 1'b1;
			send_wait        <= fast_run ? 0 : $urandom_range(0, send_max);
			sent_cnt         <= sent_cnt + 1;
			if (sent_cnt[5:0] == 0) send_max <= ($urandom_range(0, 2) == 0) ? 0 : 8;
		end else begin
			tick_in_ch.valid <= 1'b0;
		end
	end

	// Predict the result of each accepted tick beat
	always @(posedge clk) begin
		if (arst_n && tick_in_ch.valid && tick_in_ch.ready)
			expected_reports.push_back(predict_tick(tick_in_ch.data));
	end

	// Result receiver: random stalls per beat, long hold-offs at a few points
	int recv_wait;
	int recv_max;
	int stall_left;
	int taken_cnt;
	always @(posedge clk or negedge arst_n) begin : result_sink
		int gap;
		if (!arst_n) begin
			tick_out_ch.ready <= 1'b0;
			recv_wait         <= 0;
			recv_max          <= 8;
			stall_left        <= 0;
			taken_cnt         <= 0;
		end else if (tick_out_ch.valid && tick_out_ch.ready) begin
			taken_cnt <= taken_cnt + 1;
			if (taken_cnt[5:0] == 0) recv_max <= ($urandom_range(0, 2) == 0) ? 0 : 8;
			if (taken_cnt == 250 || taken_cnt == 900 || taken_cnt == 1500) begin
				stall_left        <= STALL_CYCLES;
				tick_out_ch.ready <= 1'b0;
			end else begin
				gap               = fast_run ? 0 : $urandom_range(0, recv_max);
				recv_wait         <= gap;
				tick_out_ch.ready <= (gap == 0);
			end
		end else if (stall_left != 0) begin
			stall_left        <= stall_left - 1;
			tick_out_ch.ready <= (stall_left == 1);
		end else if (recv_wait != 0) begin
			recv_wait         <= recv_wait - 1;
			tick_out_ch.ready <= (recv_wait == 1);
		end else begin
			tick_out_ch.ready <= 1'b1;
		end
	end

	// Compare each result beat with the oldest prediction
	always @(posedge clk) begin : result_check
		tick_out_t want;
		if (arst_n && tick_out_ch.valid && tick_out_ch.ready) begin
			if (expected_reports.size() == 0) begin
				$error("result beat with no tick outstanding");
				fail_count++;
			end else begin
				want = expected_reports.pop_front();
				check_field("charge_on", 16'(want.charge_on),
					16'(tick_out_ch.data.charge_on));
				check_field("contrast_duty", 16'(want.contrast_duty),
					16'(tick_out_ch.data.contrast_duty));
				check_field("led_on", 16'(want.led_on),
					16'(tick_out_ch.data.led_on));
				check_field("power_mode", 16'(want.power_mode),
					16'(tick_out_ch.data.power_mode));
				check_field("watchdog_kick", 16'(want.watchdog_kick),
					16'(tick_out_ch.data.watchdog_kick));
				check_field("seconds", 16'(want.seconds),
					16'(tick_out_ch.data.seconds));
				check_field("milliseconds", 16'(want.milliseconds),
					16'(tick_out_ch.data.milliseconds));
				check_field("idle_seconds", 16'(want.idle_seconds),
					16'(tick_out_ch.data.idle_seconds));
				check_field("sleep_seconds", 16'(want.sleep_seconds),
					16'(tick_out_ch.data.sleep_seconds));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		logic [MV_W-1:0] thr [5];
		int              n;
		logic            late;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_MAX_RATED;
		cfg_wdata         = '0;
		tick_in_ch.valid  = 1'b0;
		tick_in_ch.data   = '0;
		tick_out_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Full battery straight out of start, then every band with default limits
		write_reg(CFG_SAMPLE_EN, 14'd1);
		queue_tick(14'd5000, 1'b0, 1'b0);
		queue_tick(14'd4950, 1'b0, 1'b0);
		queue_tick(14'd4950, 1'b0, 1'b0);
		queue_tick(14'd16383, 1'b1, 1'b0);
		queue_tick(14'd0, 1'b0, 1'b0);
		queue_tick(14'd0, 1'b0, 1'b1);
		queue_tick(14'd3601, 1'b0, 1'b0);
		queue_tick(14'd3600, 1'b1, 1'b1);
		queue_tick(14'd4001, 1'b0, 1'b0);
		queue_tick(14'd4101, 1'b0, 1'b0);
		queue_tick(14'd4301, 1'b0, 1'b0);
		queue_tick(14'd4501, 1'b0, 1'b0);
		queue_tick(14'd4601, 1'b0, 1'b0);
		queue_tick(14'd4801, 1'b0, 1'b0);
		queue_tick(14'd4900, 1'b0, 1'b0);
		queue_tick(14'd5300, 1'b0, 1'b0);
		queue_tick(14'd5301, 1'b0, 1'b0);
		wait_drained();

		// Forced charge with the watchdog held, then release into too low and full
		write_reg(CFG_FORCE_CHARGE, 14'd1);
		write_reg(CFG_WDOG_HOLD, 14'd1);
		queue_tick(14'd4200, 1'b0, 1'b0);
		queue_tick(14'd0, 1'b0, 1'b0);
		queue_tick(14'd16383, 1'b0, 1'b0);
		wait_drained();
		write_reg(CFG_FORCE_CHARGE, 14'd0);
		write_reg(CFG_WDOG_HOLD, 14'd0);
		queue_tick(14'd0, 1'b0, 1'b0);
		queue_tick(14'd5000, 1'b0, 1'b0);
		wait_drained();

		// Sampling off: the stored reading must not move
		write_reg(CFG_SAMPLE_EN, 14'd0);
		queue_tick(14'd9999, 1'b0, 1'b0);
		wait_drained();

		// Random phases over limit sets; the last one runs unpaced
		for (int phase = 0; phase < 9; phase++) begin
			for (int i = 0; i < 5; i++) thr[i] = $urandom_range(0, 16383);
			case (phase)
				0, 7, 8: thr = '{MAX_RATED_RST, BATTERY_FULL_RST, NO_EXTERNAL_RST,
					ON_BATTERY_RST, BATTERY_LOW_RST};
				1:       thr = '{default: '0};
				2:       thr = '{default: 14'h3FFF};
				3, 6:    thr.rsort();
				default: ;
			endcase
			for (int i = 0; i < 5; i++) write_reg(cfg_reg_t'(i), thr[i]);
			write_reg(CFG_SAMPLE_EN, (phase == 6) ? 14'd0 : 14'd1);
			write_reg(CFG_WDOG_HOLD,
				(phase == 5 || (phase < 8 && $urandom_range(0, 2) == 0)) ? 14'd1 : 14'd0);
			write_reg(CFG_FORCE_CHARGE, (phase == 5) ? 14'd1 : 14'd0);

			fast_run = (phase == 8);
			n = (phase == 8) ? LONG_ITEMS : PHASE_ITEMS;
			for (int k = 0; k < n; k++) begin
				// keep most of the unpaced run free of clears so the counters keep climbing
				late = (phase != 8) || (k >= LONG_ITEMS - 40);
				queue_tick(pick_sample(), late && $urandom_range(0, 11) == 0,
					late && $urandom_range(0, 11) == 0);
			end
			wait_drained();
		end
		fast_run = 1'b0;

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
